// ===== hw/rtl/icv6ck_pkg.sv =====
// shared constants, types and ones' complement helper for the icmpv6 checksum engine
`default_nettype none

package icv6ck_pkg;

    // field and state widths
    localparam int unsigned CountW     = 16;
    localparam int unsigned SumW       = 16;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned AddrCountW = 6;

    // pseudo-header and message layout
    localparam int unsigned AddressBytes           = 32;
    localparam int unsigned NextHeaderIcmpv6       = 58;
    localparam int unsigned ChecksumHighIndex      = 2;
    localparam int unsigned ChecksumLowIndex       = 3;
    localparam int unsigned MinMessageBytes        = 4;
    localparam int unsigned MaxMessageBytesDefault = 65535;

    // command codes
    localparam logic CmdAddress = 1'b0;
    localparam logic CmdMessage = 1'b1;

    typedef logic [SumW-1:0] word_t;

    // running state captured on the last byte of a message
    typedef struct packed {
        word_t sum;
        word_t pad;
        word_t count;
        word_t recv;
        logic  too_short;
        logic  addr_incomplete;
        logic  overflow;
    } tail_t;

    // partial sums between the two finishing stages
    typedef struct packed {
        word_t sum_part;
        word_t len_part;
        word_t recv;
        logic  too_short;
        logic  addr_incomplete;
        logic  overflow;
    } mid_t;

    // 16-bit ones' complement add with end-around carry
    function automatic word_t oc_add(input word_t a, input word_t b);
        logic [SumW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[SumW-1:0] + {{(SumW-1){1'b0}}, s[SumW]};
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/icv6ck_accum.sv =====
// byte pairing, running sum and message bookkeeping, with capture register for the tail
`default_nettype none

module icv6ck_accum #(
    parameter int unsigned MAX_MESSAGE_BYTES = icv6ck_pkg::MaxMessageBytesDefault
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            command,
    input  wire logic [icv6ck_pkg::ByteW-1:0]    data_byte,
    input  wire logic                            last,
    input  wire logic                            tail_ready,
    output logic                                 tail_valid,
    output icv6ck_pkg::tail_t                    tail
);
    import icv6ck_pkg::*;

    localparam logic [CountW-1:0]     MaxCount  = CountW'(MAX_MESSAGE_BYTES);
    localparam logic [CountW-1:0]     CsumHigh  = CountW'(ChecksumHighIndex);
    localparam logic [CountW-1:0]     CsumLow   = CountW'(ChecksumLowIndex);
    localparam logic [CountW-1:0]     MinCount  = CountW'(MinMessageBytes);
    localparam logic [AddrCountW-1:0] AddrFull  = AddrCountW'(AddressBytes);

    word_t                 sum_reg, sum_next;
    logic [CountW-1:0]     count_reg, count_next;
    logic [AddrCountW-1:0] addr_cnt_reg, addr_cnt_next;
    logic [ByteW-1:0]      held_reg, held_next;
    logic                  phase_reg, phase_next;
    word_t                 recv_reg, recv_next;
    logic                  ovf_reg, ovf_next;

    logic                  tail_valid_reg;
    tail_t                 tail_reg;

    logic                  accept;
    logic                  ends_message;
    logic                  do_add;
    word_t                 addend;
    logic                  phase_eff;
    logic [ByteW-1:0]      byte_eff;

    // capture stage may refill when empty or when the finisher takes it
    assign in_stall     = tail_valid_reg && !tail_ready;
    assign accept       = in_valid && !in_stall;
    assign ends_message = (command == CmdMessage) && last;
    assign tail_valid   = tail_valid_reg;
    assign tail         = tail_reg;

    // next state for one byte: at most one ones' complement add
    always_comb
    begin
        count_next    = count_reg;
        addr_cnt_next = addr_cnt_reg;
        held_next     = held_reg;
        phase_next    = phase_reg;
        recv_next     = recv_reg;
        ovf_next      = ovf_reg;
        do_add        = 1'b0;
        addend        = '0;
        phase_eff     = phase_reg;
        byte_eff      = data_byte;

        if (command == CmdAddress)
        begin
            if (count_reg == '0 && !ovf_reg && addr_cnt_reg < AddrFull)
            begin
                addr_cnt_next = addr_cnt_reg + AddrCountW'(1);
                if (!phase_reg)
                begin
                    held_next  = data_byte;
                    phase_next = 1'b1;
                end
                else
                begin
                    do_add     = 1'b1;
                    addend     = {held_reg, data_byte};
                    phase_next = 1'b0;
                end
            end
        end
        else
        begin
            // odd address count: flush the lone byte before the message starts
            if (count_reg == '0 && phase_reg)
            begin
                do_add    = 1'b1;
                addend    = {held_reg, {ByteW{1'b0}}};
                phase_eff = 1'b0;
                phase_next = 1'b0;
            end

            if (count_reg >= MaxCount)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                // checksum field bytes count as zero and are kept aside
                if (count_reg == CsumHigh)
                begin
                    recv_next = {data_byte, recv_reg[ByteW-1:0]};
                    byte_eff  = '0;
                end
                else if (count_reg == CsumLow)
                begin
                    recv_next = {recv_reg[SumW-1:ByteW], data_byte};
                    byte_eff  = '0;
                end

                if (!phase_eff)
                begin
                    held_next  = byte_eff;
                    phase_next = 1'b1;
                end
                else
                begin
                    do_add     = 1'b1;
                    addend     = {held_reg, byte_eff};
                    phase_next = 1'b0;
                end
                count_next = count_reg + CountW'(1);
            end
        end

        sum_next = do_add ? oc_add(sum_reg, addend) : sum_reg;
    end

    // running state, cleared after each message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            count_reg    <= '0;
            addr_cnt_reg <= '0;
            held_reg     <= '0;
            phase_reg    <= 1'b0;
            recv_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (ends_message)
            begin
                sum_reg      <= '0;
                count_reg    <= '0;
                addr_cnt_reg <= '0;
                held_reg     <= '0;
                phase_reg    <= 1'b0;
                recv_reg     <= '0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                sum_reg      <= sum_next;
                count_reg    <= count_next;
                addr_cnt_reg <= addr_cnt_next;
                held_reg     <= held_next;
                phase_reg    <= phase_next;
                recv_reg     <= recv_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

    // capture stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            tail_valid_reg <= accept && ends_message;
        end
    end

    // capture stage payload
    always_ff @(posedge clk)
    begin
        if (accept && ends_message)
        begin
            tail_reg.sum             <= sum_next;
            tail_reg.pad             <= phase_next ? {held_next, {ByteW{1'b0}}} : '0;
            tail_reg.count           <= count_next;
            tail_reg.recv            <= recv_next;
            tail_reg.too_short       <= count_next < MinCount;
            tail_reg.addr_incomplete <= addr_cnt_reg < AddrFull;
            tail_reg.overflow        <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/icv6ck_finish.sv =====
// two-stage checksum finish: pseudo-header tail, complement, compare and output register
`default_nettype none

module icv6ck_finish (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           tail_valid,
    output logic                                tail_ready,
    input  wire icv6ck_pkg::tail_t              tail,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [icv6ck_pkg::SumW-1:0]         computed_checksum,
    output logic [icv6ck_pkg::SumW-1:0]         arrived_checksum,
    output logic                                checksum_ok,
    output logic [icv6ck_pkg::SumW-1:0]         field_to_send,
    output logic                                too_short,
    output logic                                address_incomplete,
    output logic                                length_overflow
);
    import icv6ck_pkg::*;

    localparam word_t NextHeaderWord = SumW'(NextHeaderIcmpv6);

    logic  mid_valid_reg;
    mid_t  mid_reg;
    logic  out_valid_reg;
    logic  out_ready;
    logic  mid_ready;
    word_t total;
    word_t computed;

    // ready chain back from the output register
    assign out_ready  = !out_valid_reg || !out_stall;
    assign mid_ready  = !mid_valid_reg || out_ready;
    assign tail_ready = mid_ready;
    assign out_valid  = out_valid_reg;

    // final fold and complement
    assign total    = oc_add(mid_reg.sum_part, mid_reg.len_part);
    assign computed = ~total;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mid_ready)
            begin
                mid_valid_reg <= tail_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // padding and length words folded in parallel
    always_ff @(posedge clk)
    begin
        if (mid_ready && tail_valid)
        begin
            mid_reg.sum_part        <= oc_add(tail.sum, tail.pad);
            mid_reg.len_part        <= oc_add(tail.count, NextHeaderWord);
            mid_reg.recv            <= tail.recv;
            mid_reg.too_short       <= tail.too_short;
            mid_reg.addr_incomplete <= tail.addr_incomplete;
            mid_reg.overflow        <= tail.overflow;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_ready && mid_valid_reg)
        begin
            computed_checksum  <= computed;
            arrived_checksum   <= mid_reg.recv;
            checksum_ok        <= computed == mid_reg.recv;
            field_to_send      <= (mid_reg.recv == '0) ? computed : mid_reg.recv;
            too_short          <= mid_reg.too_short;
            address_incomplete <= mid_reg.addr_incomplete;
            length_overflow    <= mid_reg.overflow;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/icmpv6_checksum_engine_top.sv =====
// top level of the icmpv6 checksum engine
//
// Input channel: one byte per transfer (in_valid, in_stall, command, data_byte, last).
// Send the 32 pseudo-header address bytes with command 0 (source, then destination),
// then the icmpv6 message bytes with command 1, marking the final one with last.
// Throughput is one byte per cycle while in_stall is low; each byte updates the
// running sum with one ones' complement add, so bytes may follow back to back
// across messages. Output channel: one result transfer per message (out_valid,
// out_stall and the checksum fields). The result passes through a capture register,
// a stage that folds in the padding and length words, and the result register.
// When the receiver stalls, the result holds and up to two further results queue
// in the capture register and the fold stage; once the capture register holds a
// result that cannot drain, in_stall rises and every byte is held off.
// Reset clears the running state and empties the pipeline; a message in progress
// is discarded and the next byte starts a new pseudo-header.
`default_nettype none

module icmpv6_checksum_engine_top #(
    parameter int unsigned MAX_MESSAGE_BYTES = icv6ck_pkg::MaxMessageBytesDefault
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           command,
    input  wire logic [icv6ck_pkg::ByteW-1:0]   data_byte,
    input  wire logic                           last,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [icv6ck_pkg::SumW-1:0]         computed_checksum,
    output logic [icv6ck_pkg::SumW-1:0]         arrived_checksum,
    output logic                                checksum_ok,
    output logic [icv6ck_pkg::SumW-1:0]         field_to_send,
    output logic                                too_short,
    output logic                                address_incomplete,
    output logic                                length_overflow
);
    import icv6ck_pkg::*;

    logic  tail_valid;
    logic  tail_ready;
    tail_t tail;

    // per-byte accumulation
    icv6ck_accum #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .data_byte  (data_byte),
        .last       (last),
        .tail_ready (tail_ready),
        .tail_valid (tail_valid),
        .tail       (tail)
    );

    // checksum finish and result register
    icv6ck_finish u_finish (
        .clk                (clk),
        .rst_n              (rst_n),
        .tail_valid         (tail_valid),
        .tail_ready         (tail_ready),
        .tail               (tail),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .computed_checksum  (computed_checksum),
        .arrived_checksum   (arrived_checksum),
        .checksum_ok        (checksum_ok),
        .field_to_send      (field_to_send),
        .too_short          (too_short),
        .address_incomplete (address_incomplete),
        .length_overflow    (length_overflow)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/icv6ck_checker.sv =====
// port-level checks on the result channel of the icmpv6 checksum engine, with bind
`default_nettype none

module icv6ck_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [icv6ck_pkg::SumW-1:0]    computed_checksum,
    input  wire logic [icv6ck_pkg::SumW-1:0]    arrived_checksum,
    input  wire logic                           checksum_ok,
    input  wire logic [icv6ck_pkg::SumW-1:0]    field_to_send
);
    import icv6ck_pkg::*;

    // a stalled result transfer stays offered with its computed, arrived and send checksums unchanged
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(computed_checksum)
            && $stable(arrived_checksum) && $stable(field_to_send))
        else $error("result changed while stalled");

    // match flag agrees with the two checksums
    a_ok_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> checksum_ok == (computed_checksum == arrived_checksum))
        else $error("checksum_ok disagrees with checksums");

    // zero received field means the computed value is sent
    a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && arrived_checksum == '0 |-> field_to_send == computed_checksum)
        else $error("field_to_send not computed value for zero field");

    // non-zero received field is passed through
    a_send_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && arrived_checksum != '0 |-> field_to_send == arrived_checksum)
        else $error("field_to_send not received value");

endmodule

bind icmpv6_checksum_engine_top icv6ck_checker u_checker (.*);

`default_nettype wire

// ===== tb/icmpv6_checksum_engine_top_tb.sv =====
// self-checking testbench for the icmpv6 checksum engine: directed table, random packets
module icmpv6_checksum_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import icv6ck_pkg::*;

    localparam int unsigned MaxMsg     = MaxMessageBytesDefault;
    localparam int          CycleLimit = 1000000;
    localparam int          DrainWait  = 8;
    localparam int          PhaseItems = 450;
    localparam int          PhaseSums  = 20;
    localparam int          NumDirRows = 21;
    localparam int          ReportMax  = 10;

    // one byte transfer on the input channel
    typedef struct packed {
        logic             cmd;
        logic [ByteW-1:0] data;
        logic             last_mark;
    } byte_item_t;

    // one result transfer on the output channel
    typedef struct packed {
        word_t computed;
        word_t received;
        logic  ok;
        word_t send;
        logic  short_msg;
        logic  addr_inc;
        logic  ovf;
    } csum_result_t;

    // running state of the checksum engine
    typedef struct packed {
        word_t                 sum;
        word_t                 count;
        word_t                 recv;
        logic [AddrCountW-1:0] addr_cnt;
        logic [ByteW-1:0]      held;
        logic                  phase;
        logic                  ovf;
    } engine_state_t;

    typedef struct packed {
        byte_item_t   item;
        logic         typed;
        csum_result_t want;
    } dir_row_t;

    localparam csum_result_t NoSum = '0;

    // directed stimulus; typed results where they are plain to see
    localparam dir_row_t DirRows [NumDirRows] = '{
        // single zero byte, no addresses
        '{'{CmdMessage, 8'h00, 1'b1}, 1'b1,
          '{16'hFFC4, 16'h0000, 1'b0, 16'hFFC4, 1'b1, 1'b1, 1'b0}},
        // single all-ones byte, padded low half
        '{'{CmdMessage, 8'hFF, 1'b1}, 1'b1,
          '{16'h00C4, 16'h0000, 1'b0, 16'h00C4, 1'b1, 1'b1, 1'b0}},
        // odd address count, last mark on an address byte
        '{'{CmdAddress, 8'hAB, 1'b1}, 1'b0, NoSum},
        '{'{CmdMessage, 8'h01, 1'b1}, 1'b0, NoSum},
        // address byte after the message has started
        '{'{CmdMessage, 8'h00, 1'b0}, 1'b0, NoSum},
        '{'{CmdAddress, 8'h55, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'h00, 1'b1}, 1'b0, NoSum},
        // short message with only the high checksum byte
        '{'{CmdMessage, 8'h00, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'h00, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'hAA, 1'b1}, 1'b0, NoSum},
        // minimum length message without addresses
        '{'{CmdMessage, 8'h80, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'h00, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'h12, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'h34, 1'b1}, 1'b1,
          '{16'h7FC1, 16'h1234, 1'b0, 16'h1234, 1'b0, 1'b1, 1'b0}},
        // odd length message of all-ones bytes
        '{'{CmdAddress, 8'hFF, 1'b0}, 1'b0, NoSum},
        '{'{CmdAddress, 8'hFF, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'hFF, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'hFF, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'hFF, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'hFF, 1'b0}, 1'b0, NoSum},
        '{'{CmdMessage, 8'hFF, 1'b1}, 1'b0, NoSum}
    };

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             command;
    logic [ByteW-1:0] data_byte;
    logic             last;
    logic             out_valid;
    logic             out_stall;
    word_t            computed_checksum;
    word_t            arrived_checksum;
    logic             checksum_ok;
    word_t            field_to_send;
    logic             too_short;
    logic             address_incomplete;
    logic             length_overflow;

    engine_state_t sum_state;
    csum_result_t  pending_checksums [$];
    byte_item_t    burst_items [$];
    int            send_idle_pct;
    int            recv_stall_pct;
    int            items_sent;
    int            sums_planned;
    int            sums_seen;
    int            error_count;
    int            cycle_count;

    icmpv6_checksum_engine_top #(
        .MAX_MESSAGE_BYTES (MaxMsg)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .command            (command),
        .data_byte          (data_byte),
        .last               (last),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .computed_checksum  (computed_checksum),
        .arrived_checksum   (arrived_checksum),
        .checksum_ok        (checksum_ok),
        .field_to_send      (field_to_send),
        .too_short          (too_short),
        .address_incomplete (address_incomplete),
        .length_overflow    (length_overflow)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 16-bit ones' complement addition
    function automatic word_t ones_add(input word_t a, input word_t b);
        logic [SumW:0] t;
        begin
            t = (SumW+1)'(a) + (SumW+1)'(b);
            return t[SumW-1:0] + SumW'(t[SumW]);
        end
    endfunction

    // feed one byte into the high/low pairing
    function automatic void pair_in(inout engine_state_t st, input logic [ByteW-1:0] b);
        if (!st.phase)
        begin
            st.held  = b;
            st.phase = 1'b1;
        end
        else
        begin
            st.sum   = ones_add(st.sum, {st.held, b});
            st.phase = 1'b0;
        end
    endfunction

    // advance the engine by one byte; returns 1 with the checksum on a last message byte
    function automatic logic checksum_step(inout engine_state_t st, input byte_item_t it,
                                           output csum_result_t res);
        logic [ByteW-1:0] v;
        word_t            s;
        begin
            res = '0;
            if (it.cmd == CmdAddress)
            begin
                if (st.count == 0 && !st.ovf && st.addr_cnt < AddressBytes)
                begin
                    pair_in(st, it.data);
                    st.addr_cnt = st.addr_cnt + 1'b1;
                end
                return 1'b0;
            end
            // unpaired address byte closes with a zero low half
            if (st.count == 0 && st.phase)
                pair_in(st, '0);
            if (st.count >= MaxMsg)
                st.ovf = 1'b1;
            else
            begin
                v = it.data;
                if (st.count == ChecksumHighIndex)
                begin
                    st.recv[SumW-1:ByteW] = it.data;
                    v = '0;
                end
                else if (st.count == ChecksumLowIndex)
                begin
                    st.recv[ByteW-1:0] = it.data;
                    v = '0;
                end
                pair_in(st, v);
                st.count = st.count + 1'b1;
            end
            if (!it.last_mark)
                return 1'b0;
            // pad, length and next header words
            s = st.sum;
            if (st.phase)
                s = ones_add(s, {st.held, 8'h00});
            s = ones_add(s, st.count);
            s = ones_add(s, word_t'(NextHeaderIcmpv6));
            res.computed  = ~s;
            res.received  = st.recv;
            res.ok        = (res.computed == st.recv);
            res.send      = (st.recv == 0) ? res.computed : st.recv;
            res.short_msg = (st.count < MinMessageBytes);
            res.addr_inc  = (st.addr_cnt < AddressBytes);
            res.ovf       = st.ovf;
            st = '0;
            return 1'b1;
        end
    endfunction

    function automatic byte_item_t rand_item(input logic cmd, input logic lst);
        byte_item_t it;
        begin
            it.cmd       = cmd;
            it.data      = ByteW'($urandom_range(255));
            it.last_mark = lst;
            return it;
        end
    endfunction

    // drive one byte transfer and record its checksum once taken
    task automatic send_item(input byte_item_t it, input logic typed, input csum_result_t want);
        csum_result_t res;
        logic         has_sum;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            command   <= it.cmd;
            data_byte <= it.data;
            last      <= it.last_mark;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            items_sent++;
            has_sum = checksum_step(sum_state, it, res);
            if (has_sum)
            begin
                pending_checksums.push_back(typed ? want : res);
                sums_planned++;
            end
        end
    endtask

    // build one random packet: mostly well-formed, some broken, some noise
    function automatic void plan_burst();
        int            kind;
        int            n_addr;
        int            n_msg;
        int            len_pick;
        int            field_mode;
        engine_state_t probe;
        csum_result_t  res;
        begin
            burst_items.delete();
            kind = $urandom_range(99);
            if (kind < 12)
            begin
                repeat ($urandom_range(1, 12))
                    burst_items.push_back(rand_item(1'($urandom_range(1)),
                                                    $urandom_range(7) == 0));
                return;
            end
            n_addr   = (kind < 75) ? AddressBytes : $urandom_range(0, AddressBytes + 8);
            len_pick = $urandom_range(99);
            if (len_pick < 10)
                n_msg = $urandom_range(1, MinMessageBytes - 1);
            else if (len_pick < 95)
                n_msg = $urandom_range(MinMessageBytes, 64);
            else
                n_msg = $urandom_range(65, 300);
            for (int i = 0; i < n_addr; i++)
                burst_items.push_back(rand_item(CmdAddress, 1'($urandom_range(1))));
            for (int i = 0; i < n_msg; i++)
                burst_items.push_back(rand_item(CmdMessage, i == n_msg - 1));
            // checksum field: zero, correct or left random
            field_mode = $urandom_range(2);
            if (n_msg >= MinMessageBytes && field_mode < 2)
            begin
                burst_items[n_addr + ChecksumHighIndex].data = '0;
                burst_items[n_addr + ChecksumLowIndex].data  = '0;
                if (field_mode == 1)
                begin
                    probe = sum_state;
                    foreach (burst_items[i])
                        void'(checksum_step(probe, burst_items[i], res));
                    burst_items[n_addr + ChecksumHighIndex].data = res.computed[SumW-1:ByteW];
                    burst_items[n_addr + ChecksumLowIndex].data  = res.computed[ByteW-1:0];
                end
            end
            // late address bytes inside the message
            if (kind >= 90 && n_msg > 1)
                repeat ($urandom_range(1, 3))
                    burst_items.insert(n_addr + $urandom_range(1, n_msg - 1),
                                       rand_item(CmdAddress, 1'($urandom_range(1))));
        end
    endfunction

    // hold the input side off until every checksum has come out
    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            while (pending_checksums.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic check_field(input string fname, input word_t want, input word_t got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= ReportMax)
                $display("result %0d: %s expected %h, got %h", sums_seen, fname, want, got);
        end
    endtask

    // output side: random stall, compare each result transfer with the oldest checksum
    always @(posedge clk)
    begin : result_monitor
        csum_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            cycle_count++;
            if (out_valid && !out_stall)
            begin
                if (pending_checksums.size() == 0)
                begin
                    error_count++;
                    if (error_count <= ReportMax)
                        $display("result %0d: transfer with no checksum pending", sums_seen);
                end
                else
                begin
                    want = pending_checksums.pop_front();
                    check_field("computed_checksum", want.computed, computed_checksum);
                    check_field("arrived_checksum", want.received, arrived_checksum);
                    check_field("checksum_ok", word_t'(want.ok), word_t'(checksum_ok));
                    check_field("field_to_send", want.send, field_to_send);
                    check_field("too_short", word_t'(want.short_msg), word_t'(too_short));
                    check_field("address_incomplete", word_t'(want.addr_inc),
                                word_t'(address_incomplete));
                    check_field("length_overflow", word_t'(want.ovf), word_t'(length_overflow));
                end
                sums_seen++;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // run time limit
    initial
    begin
        wait (cycle_count >= CycleLimit);
        $display("icmpv6_checksum_engine_top_tb: done, errors");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int send_pct [4];
        int stall_pct [4];
        int phase_items;
        int phase_sums;
        send_pct  = '{0, 77, 0, 10};
        stall_pct = '{0, 0, 77, 10};
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CmdAddress;
        data_byte      = '0;
        last           = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        sums_planned   = 0;
        sum_state      = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < NumDirRows; r++)
            send_item(DirRows[r].item, DirRows[r].typed, DirRows[r].want);
        drain_results();

        // random packets under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = stall_pct[p];
            phase_items    = items_sent;
            phase_sums     = sums_planned;
            while (items_sent - phase_items < PhaseItems || sums_planned - phase_sums < PhaseSums)
            begin
                plan_burst();
                foreach (burst_items[i])
                    send_item(burst_items[i], 1'b0, NoSum);
            end
            drain_results();
        end

        repeat (DrainWait) @(posedge clk);
        if (error_count == 0 && pending_checksums.size() == 0)
            $display("icmpv6_checksum_engine_top_tb: done, clean");
        else
            $display("icmpv6_checksum_engine_top_tb: done, errors");
        $finish;
    end

endmodule
